### rtl/pmc_pkg.sv
// shared types and constants for the power management control / smi register block
// no dependencies
package pmc_pkg;

    localparam logic [2:0] KIND_SMI_WR = 3'd0;
    localparam logic [2:0] KIND_SMI_RD = 3'd1;
    localparam logic [2:0] KIND_CTL_WR = 3'd2;
    localparam logic [2:0] KIND_CTL_RD = 3'd3;
    localparam logic [2:0] KIND_APM_WR = 3'd4;

    // bit positions in power control and enable/status byte 0
    localparam int SLEEP_EN_BIT     = 13;
    localparam int GLB_RELEASE_BIT  = 2;
    localparam int APM_SMI_BIT      = 5;
    localparam int SLEEP_SMI_BIT    = 4;
    localparam int RELEASE_SMI_BIT  = 2;

    localparam logic [2:0] SLP_TYPE_STR  = 3'd5;
    localparam logic [2:0] SLP_TYPE_STD  = 3'd6;
    localparam logic [2:0] SLP_TYPE_SOFT = 3'd7;

    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_STR  = 2'd1;
    localparam logic [1:0] ACT_STD  = 2'd2;
    localparam logic [1:0] ACT_SOFT = 2'd3;

    typedef struct packed {
        logic [2:0] kind;
        logic [2:0] offset;
        logic [7:0] data;
    } pmc_req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       smi_raise;
        logic [1:0] sleep_action;
    } pmc_rsp_t;

endpackage

### rtl/pmc_in_stage.sv
// input register for requests, one request held until the core takes it
// depends on pmc_pkg
module pmc_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pmc_pkg::pmc_req_t in_req,
    output logic              req_valid,
    input  logic              req_take,
    output pmc_pkg::pmc_req_t req
);
    import pmc_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    pmc_req_t req_reg;

    assign in_ready   = !valid_reg || req_take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !req_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg <= in_req;
        end
    end

    assign req_valid = valid_reg;
    assign req       = req_reg;

endmodule

### rtl/pmc_core.sv
// register state, access evaluation and result register
// depends on pmc_pkg
module pmc_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_take,
    input  pmc_pkg::pmc_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output pmc_pkg::pmc_rsp_t rsp
);
    import pmc_pkg::*;

    logic [7:0]  smi_enable_reg [4];
    logic [7:0]  smi_status_reg [4];
    logic [15:0] power_control_reg;
    logic [15:0] power_control_next;
    logic [7:0]  status0_next;
    logic        rsp_valid_reg;
    pmc_rsp_t    rsp_reg;
    pmc_rsp_t    rsp_next;
    logic        en_wr;
    logic        st_wr;
    logic        sleep_smi;
    logic        rel_smi;
    logic        apm_smi;
    logic [2:0]  slp_type;
    logic [1:0]  idx;

    assign req_take = req_valid && (!rsp_valid_reg || rsp_ready);
    assign idx      = req.offset[1:0];

    always_comb
    begin
        power_control_next = power_control_reg;
        status0_next       = smi_status_reg[0];
        en_wr              = 1'b0;
        st_wr              = 1'b0;
        sleep_smi          = 1'b0;
        rel_smi            = 1'b0;
        apm_smi            = 1'b0;
        slp_type           = 3'd0;
        rsp_next           = '0;
        unique case (req.kind)
            KIND_SMI_WR:
            begin
                en_wr = !req.offset[2];
                st_wr = req.offset[2];
                if (req.offset[2] && idx == 2'd0)
                begin
                    status0_next = smi_status_reg[0] & req.data;
                end
            end
            KIND_SMI_RD:
            begin
                rsp_next.read_data = req.offset[2] ? smi_status_reg[idx] : smi_enable_reg[idx];
            end
            KIND_CTL_WR:
            begin
                if (req.offset[0])
                begin
                    power_control_next = {req.data, power_control_reg[7:0]};
                end
                else
                begin
                    power_control_next = {power_control_reg[15:8], req.data};
                end
                slp_type = power_control_next[12:10];
                if (power_control_next[SLEEP_EN_BIT])
                begin
                    if (smi_enable_reg[0][SLEEP_SMI_BIT])
                    begin
                        sleep_smi = 1'b1;
                    end
                    else
                    begin
                        priority if (slp_type == SLP_TYPE_STR)
                            rsp_next.sleep_action = ACT_STR;
                        else if (slp_type == SLP_TYPE_STD)
                            rsp_next.sleep_action = ACT_STD;
                        else if (slp_type == SLP_TYPE_SOFT)
                            rsp_next.sleep_action = ACT_SOFT;
                        else
                            rsp_next.sleep_action = ACT_NONE;
                    end
                end
                rel_smi = power_control_next[GLB_RELEASE_BIT]
                          && smi_enable_reg[0][RELEASE_SMI_BIT];
                status0_next[SLEEP_SMI_BIT]   = smi_status_reg[0][SLEEP_SMI_BIT] | sleep_smi;
                status0_next[RELEASE_SMI_BIT] = smi_status_reg[0][RELEASE_SMI_BIT] | rel_smi;
                rsp_next.smi_raise = sleep_smi || rel_smi;
            end
            KIND_CTL_RD:
            begin
                rsp_next.read_data = req.offset[0] ? power_control_reg[15:8]
                                                   : power_control_reg[7:0];
            end
            KIND_APM_WR:
            begin
                apm_smi = smi_enable_reg[0][APM_SMI_BIT];
                status0_next[APM_SMI_BIT] = smi_status_reg[0][APM_SMI_BIT] | apm_smi;
                rsp_next.smi_raise = apm_smi;
            end
            default:
            begin
                rsp_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                smi_enable_reg[i] <= 8'h00;
                smi_status_reg[i] <= 8'h00;
            end
            power_control_reg <= 16'h0000;
        end
        else if (req_take)
        begin
            if (en_wr)
            begin
                smi_enable_reg[idx] <= req.data;
            end
            // status byte 0 also collects latched smi causes
            if (st_wr && idx != 2'd0)
            begin
                smi_status_reg[idx] <= smi_status_reg[idx] & req.data;
            end
            smi_status_reg[0] <= status0_next;
            power_control_reg <= power_control_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (req_take)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### rtl/pm_control_smi_register_block_unit.sv
// top level of the power management control and smi enable/status register block
// depends on pmc_pkg, pmc_in_stage, pmc_core
//
// Byte accesses to four smi enable bytes, four smi status bytes (write clears the
// bits written as zero), the 16-bit power control register and the apm command
// port. One request is accepted every clock cycle while the input register is empty or
// being emptied; each request is registered at the input and evaluated against the
// register state when the core takes it, and the registered result stays until taken.
// Only the output and input registers stand between the ports, so throughput
// is one request per cycle whenever the result side takes one result per cycle.
module pm_control_smi_register_block_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] kind,
    input  logic [2:0] offset,
    input  logic [7:0] data,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] read_data,
    output logic       smi_raise,
    output logic [1:0] sleep_action
);
    import pmc_pkg::*;

    pmc_req_t in_req;
    pmc_req_t req;
    pmc_rsp_t rsp;
    logic     req_valid;
    logic     req_take;

    assign in_req.kind   = kind;
    assign in_req.offset = offset;
    assign in_req.data   = data;

    pmc_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_req    (in_req),
        .req_valid (req_valid),
        .req_take  (req_take),
        .req       (req)
    );

    pmc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_take  (req_take),
        .req       (req),
        .rsp_valid (out_valid),
        .rsp_ready (out_ready),
        .rsp       (rsp)
    );

    assign read_data    = rsp.read_data;
    assign smi_raise    = rsp.smi_raise;
    assign sleep_action = rsp.sleep_action;

endmodule
